FILE: design/pcm8_pkg.sv
// ----------------------------------------------------------------------------
// PCM player package
// Shared types, register codes and constants of the eight-channel PCM player.
// ----------------------------------------------------------------------------
package pcm8_pkg;

  localparam int NUM_CHANNELS    = 8;
  localparam int PHASE_FRAC_BITS = 11;
  localparam int CH_W            = 3;
  localparam int WAVE_AW         = 16;

  localparam logic [26:0] PHASE_MASK = 27'h7FFFFFF;
  localparam logic [7:0]  LOOP_MARK  = 8'hFF;
  localparam logic [7:0]  CTRL_SOUND = 8'h80;
  localparam logic [7:0]  CTRL_CHSEL = 8'h40;

  typedef enum logic [1:0] {
    REQ_WR     = 2'd0,
    REQ_RD     = 2'd1,
    REQ_WAVE   = 2'd2,
    REQ_RENDER = 2'd3
  } req_t;

  localparam logic [4:0] REG_VOL    = 5'd0;
  localparam logic [4:0] REG_PAN    = 5'd1;
  localparam logic [4:0] REG_STEP_L = 5'd2;
  localparam logic [4:0] REG_STEP_H = 5'd3;
  localparam logic [4:0] REG_LOOP_L = 5'd4;
  localparam logic [4:0] REG_LOOP_H = 5'd5;
  localparam logic [4:0] REG_START  = 5'd6;
  localparam logic [4:0] REG_CTRL   = 5'd7;
  localparam logic [4:0] REG_OFF    = 5'd8;

  // commands from controller to datapath
  typedef struct packed {
    logic           do_reg;     // handle register/wave request (one cycle)
    logic           clr_acc;    // clear accumulators
    logic           rd_issue;   // issue wave read for channel at phase
    logic           rd_loop;    // issue wave read at loop address
    logic           latch_byte; // capture first byte, update phase
    logic           latch_loop; // capture refetched byte
    logic           mul1;       // stage 1 multiply
    logic           mul2;       // stage 2 multiply
    logic           mul3;       // reciprocal multiply
    logic           acc;        // correct and accumulate
    logic           idle_ch;    // reload phase from start page
    logic [CH_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic ch_active;
    logic byte_is_loop;
  } sts_t;

endpackage

FILE: design/pcm8_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module pcm8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/pcm8_datapath.sv
// ----------------------------------------------------------------------------
// PCM player datapath
// Channel registers, wave RAM, scaling multipliers and stereo accumulators.
// ----------------------------------------------------------------------------
module pcm8_datapath import pcm8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  req_type,
  input  logic [4:0]  reg_index,
  input  logic [11:0] wave_offset,
  input  logic [7:0]  write_data,
  output logic [7:0]  read_data,
  output logic [15:0] left_sample,
  output logic [15:0] right_sample
);

  logic [7:0]  vol_r   [8];
  logic [7:0]  pan_r   [8];
  logic [15:0] step_r  [8];
  logic [15:0] loop_r  [8];
  logic [7:0]  start_r [8];
  logic [26:0] phase_r [8];
  logic [7:0]  off_r;
  logic        sound_r;
  logic [3:0]  bank_r;
  logic [2:0]  csel_r;
  logic [7:0]  rdat_r;
  logic [7:0]  byte_r;
  logic [15:0] accl_r, accr_r;
  // magnitude pipeline
  logic        neg_r;
  logic [14:0] mv_r;             // |s| * vol
  logic [18:0] pl_r, pr_r;       // * nibble
  logic [50:0] ql_r, qr_r;       // * reciprocal

  logic [7:0]  rdata;
  logic        ram_we, ram_re;
  logic [15:0] ram_raddr, ram_waddr;
  logic [2:0]  ch;
  logic [26:0] loop_ph;
  logic [26:0] n;
  logic [7:0]  rd_nxt;
  logic [2:0]  pn;

  assign ch      = cmd.ch;
  assign loop_ph = {loop_r[ch], 11'd0} & PHASE_MASK;
  assign pn      = reg_index[3:1];
  assign n       = (phase_r[ch] + {11'd0, step_r[ch]}) & PHASE_MASK;

  assign ram_we    = cmd.do_reg && (req_t'(req_type) == REQ_WAVE);
  assign ram_waddr = {bank_r, 12'd0} + {4'd0, wave_offset};
  assign ram_re    = cmd.rd_issue || cmd.rd_loop;
  assign ram_raddr = cmd.rd_loop ? loop_ph[26:11] : phase_r[ch][26:11];

  pcm8_ram #(.WIDTH(8), .DEPTH(65536)) u_wave (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(write_data),
    .re(ram_re), .raddr(ram_raddr), .rdata(rdata)
  );

  assign sts.ch_active    = !off_r[ch] && sound_r;
  assign sts.byte_is_loop = (rdata == LOOP_MARK);

  always_comb begin
    rd_nxt = 8'd0;
    unique case (reg_index)
      REG_VOL:    rd_nxt = vol_r[csel_r];
      REG_PAN:    rd_nxt = pan_r[csel_r];
      REG_STEP_L: rd_nxt = step_r[csel_r][7:0];
      REG_STEP_H: rd_nxt = step_r[csel_r][15:8];
      REG_LOOP_L: rd_nxt = loop_r[csel_r][7:0];
      REG_LOOP_H: rd_nxt = loop_r[csel_r][15:8];
      REG_START:  rd_nxt = start_r[csel_r];
      REG_OFF:    rd_nxt = off_r;
      default: begin
        if (reg_index[4]) begin
          rd_nxt = reg_index[0] ? phase_r[pn][26:19] : phase_r[pn][18:11];
        end
      end
    endcase
  end

  // sign-magnitude value of the captured byte
  logic       bneg;
  logic [6:0] bmag;
  always_comb begin
    bneg = !byte_r[7];
    bmag = byte_r[7] ? ((byte_r == LOOP_MARK) ? 7'd0 : byte_r[6:0]) : byte_r[6:0];
  end

  // floor(p * 4096 / 0x7698F) as (p * ceil(2^50 / 0x7698F)) >> 38, exact for p < 2^19
  localparam logic [31:0] RECIP = 32'd2317739503;
  logic [50:0] ml, mr;
  assign ml = {32'd0, pl_r} * {19'd0, RECIP};
  assign mr = {32'd0, pr_r} * {19'd0, RECIP};

  logic [12:0] cl, cr;
  assign cl = ql_r[50:38];
  assign cr = qr_r[50:38];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        vol_r[i] <= 8'd0; pan_r[i] <= 8'd0; step_r[i] <= 16'd0;
        loop_r[i] <= 16'd0; start_r[i] <= 8'd0; phase_r[i] <= 27'd0;
      end
      off_r   <= 8'hFF;
      sound_r <= 1'b0;
      bank_r  <= 4'd0;
      csel_r  <= 3'd0;
      rdat_r  <= 8'd0;
      accl_r  <= 16'd0;
      accr_r  <= 16'd0;
    end else begin
      if (cmd.do_reg) begin
        rdat_r <= (req_t'(req_type) == REQ_RD) ? rd_nxt : 8'd0;
        accl_r <= 16'd0;
        accr_r <= 16'd0;
        if (req_t'(req_type) == REQ_WR) begin
          unique case (reg_index)
            REG_VOL:    vol_r[csel_r] <= write_data;
            REG_PAN:    pan_r[csel_r] <= write_data;
            REG_STEP_L: step_r[csel_r][7:0] <= write_data;
            REG_STEP_H: step_r[csel_r][15:8] <= write_data;
            REG_LOOP_L: loop_r[csel_r][7:0] <= write_data;
            REG_LOOP_H: loop_r[csel_r][15:8] <= write_data;
            REG_START:  start_r[csel_r] <= write_data;
            REG_CTRL: begin
              sound_r <= |(write_data & CTRL_SOUND);
              if (|(write_data & CTRL_CHSEL)) begin
                csel_r <= write_data[2:0];
              end else begin
                bank_r <= write_data[3:0];
              end
            end
            REG_OFF:    off_r <= write_data;
            default: ;
          endcase
        end
      end
      if (cmd.clr_acc) begin
        accl_r <= 16'd0;
        accr_r <= 16'd0;
        rdat_r <= 8'd0;
      end
      if (cmd.idle_ch) begin
        phase_r[ch] <= {start_r[ch], 19'd0} & PHASE_MASK;
      end
      if (cmd.latch_byte) begin
        byte_r <= rdata;
        phase_r[ch] <= (rdata == LOOP_MARK) ? loop_ph : n;
      end
      if (cmd.latch_loop) begin
        byte_r <= rdata;
      end
      if (cmd.acc) begin
        accl_r <= neg_r ? accl_r - {3'd0, cl} : accl_r + {3'd0, cl};
        accr_r <= neg_r ? accr_r - {3'd0, cr} : accr_r + {3'd0, cr};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      neg_r <= bneg && (bmag != 7'd0);
      mv_r  <= 15'({8'd0, bmag} * {7'd0, vol_r[ch]});
    end
    if (cmd.mul2) begin
      pl_r <= 19'({4'd0, mv_r} * {15'd0, pan_r[ch][3:0]});
      pr_r <= 19'({4'd0, mv_r} * {15'd0, pan_r[ch][7:4]});
    end
    if (cmd.mul3) begin
      ql_r <= ml;
      qr_r <= mr;
    end
  end

  assign read_data    = rdat_r;
  assign left_sample  = accl_r;
  assign right_sample = accr_r;

`ifndef SYNTH
  a_off_reset: assert property (@(posedge clk) !rst_n |=> off_r == 8'hFF)
    else $error("off mask not set at reset");
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_reg && req_t'(req_type) != REQ_RD |=> rdat_r == 8'd0)
    else $error("read data not zero");
  a_rd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd_issue && cmd.rd_loop))
    else $error("two wave reads at once");
`endif

endmodule

FILE: design/pcm8_ctrl.sv
// ----------------------------------------------------------------------------
// PCM player controller
// Sequences requests and the per-channel render steps; owns the handshake.
// ----------------------------------------------------------------------------
module pcm8_ctrl import pcm8_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  output logic       out_valid,
  input  logic       out_stall,
  output cmd_t       cmd,
  input  sts_t       sts
);

  typedef enum logic [3:0] {
    S_IDLE, S_CH, S_WAIT, S_BYTE, S_LWAIT, S_LBYTE, S_M1, S_M2, S_M3, S_ACC, S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic            ovalid_r, ovalid_nxt;
  logic            accept;

  assign in_stall  = (state_r != S_IDLE) || ovalid_r;
  assign accept    = in_valid && !in_stall;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ch_nxt     = ch_r;
    ovalid_nxt = ovalid_r && out_stall;
    cmd        = '0;
    cmd.ch     = ch_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (req_t'(in_req_type) == REQ_RENDER) begin
            cmd.clr_acc = 1'b1;
            ch_nxt      = '0;
            state_nxt   = S_CH;
          end else begin
            cmd.do_reg = 1'b1;
            ovalid_nxt = 1'b1;
          end
        end
      end
      S_CH: begin
        if (sts.ch_active) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_WAIT;
        end else begin
          cmd.idle_ch = 1'b1;
          state_nxt   = S_OUT;
        end
      end
      S_WAIT: state_nxt = S_BYTE;
      S_BYTE: begin
        cmd.latch_byte = 1'b1;
        state_nxt      = sts.byte_is_loop ? S_LWAIT : S_M1;
        cmd.rd_loop    = sts.byte_is_loop;
      end
      S_LWAIT: state_nxt = S_LBYTE;
      S_LBYTE: begin
        cmd.latch_loop = 1'b1;
        state_nxt      = S_M1;
      end
      S_M1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.mul3  = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (32'(ch_r) == NUM_CHANNELS - 1) begin
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_CH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ch_r     <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ch_r     <= ch_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall)
    else $error("accept while busy");
  a_out_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && 32'(ch_r) == NUM_CHANNELS - 1 |=> out_valid)
    else $error("frame not delivered");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped");
`endif

endmodule

FILE: design/eight_channel_pcm_wave_player_core.sv
// ----------------------------------------------------------------------------
// Eight-channel PCM wave player
// Register, wave RAM and render requests in; one result transaction each.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel carries one request per transaction: register write,
//   register read, wave RAM write into the selected bank, or a frame render.
//   out_* channel returns one transaction per request: read_data for reads,
//   left/right samples for renders, zero elsewhere.
//   A register or wave request's result is valid from the next cycle; the next
//   request is taken in the cycle after that result is taken.
//   A render walks the eight channels in turn: a silent channel reloads its
//   phase from the start page, a playing one fetches, scales and accumulates
//   a byte, and the loop mark forces a refetch through the single wave RAM read port.
//   One request is in flight at a time; in_stall is high while busy or while
//   a result waits. out_valid holds with stable data while out_stall is high.
//   Reset (rst_n low, synchronous) disables all channels, clears the channel
//   registers and sound enable; wave RAM contents are not cleared.
// ----------------------------------------------------------------------------
module eight_channel_pcm_wave_player_core import pcm8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [4:0]  in_reg_index,
  input  logic [11:0] in_wave_offset,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample
);

  cmd_t cmd;
  sts_t sts;

  pcm8_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts)
  );

  pcm8_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .req_type(in_req_type), .reg_index(in_reg_index),
    .wave_offset(in_wave_offset), .write_data(in_write_data),
    .read_data(out_read_data), .left_sample(out_left_sample),
    .right_sample(out_right_sample)
  );

endmodule
